[design/acdam_pkg.sv]
// ----------------------------------------------------------------------------
// acdam_pkg
// Shared types and constants of the double-array Aho-Corasick match core.
// ----------------------------------------------------------------------------
package acdam_pkg;

	localparam int NODE_W  = 8;
	localparam int BASE_W  = 8;
	localparam int CHECK_W = 9;
	localparam int FAIL_W  = 8;
	localparam int SYM_W   = 5;
	localparam int COUNT_W = 8;
	localparam int TOTAL_W = 16;

	// largest store that an 8-bit node index can reach
	localparam int NODE_SPACE = 1 << NODE_W;

	localparam logic [NODE_W-1:0]  ROOT_NODE  = NODE_W'(1);
	localparam logic [NODE_W-1:0]  NULL_NODE  = '0;
	localparam logic [NODE_W-1:0]  WALK_LIMIT = NODE_W'(255);
	localparam logic [TOTAL_W-1:0] TOTAL_MAX  = '1;

	// kind of an input word, carried in tuser
	localparam logic MODE_LOAD   = 1'b0;
	localparam logic MODE_SYMBOL = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FAIL_RD,
		ST_EDGE,
		ST_CHECK,
		ST_CHAIN_RD,
		ST_CHAIN_EV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [BASE_W-1:0]         base;
		logic signed [CHECK_W-1:0] check;
		logic [FAIL_W-1:0]         fail;
	} entry_t;

	typedef struct packed {
		logic              en;
		logic [NODE_W-1:0] node;
	} rd_req_t;

	typedef struct packed {
		logic              en;
		logic [NODE_W-1:0] node;
		entry_t            entry;
	} wr_req_t;

endpackage

[design/acdam_ram.sv]
// ----------------------------------------------------------------------------
// acdam_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module acdam_ram #(
	parameter int WIDTH = 25,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[design/acdam_store.sv]
// ----------------------------------------------------------------------------
// acdam_store
// Base, check and fail tables in one RAM, with per-entry valid bits so that
// an unwritten check entry reads as its reset value. Nodes outside the store
// read as all zero.
// ----------------------------------------------------------------------------
module acdam_store #(
	parameter int TABLE_DEPTH = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  acdam_pkg::wr_req_t wr,
	input  acdam_pkg::rd_req_t rd,
	output acdam_pkg::entry_t  rd_entry
);

	localparam int MEM_DEPTH = (TABLE_DEPTH < acdam_pkg::NODE_SPACE) ?
		TABLE_DEPTH : acdam_pkg::NODE_SPACE;
	localparam int AW = $clog2(MEM_DEPTH);
	localparam logic [acdam_pkg::NODE_W:0] MEM_LIMIT = (acdam_pkg::NODE_W + 1)'(MEM_DEPTH);
	localparam int EW = $bits(acdam_pkg::entry_t);

	logic              wr_in_store;
	logic              rd_in_store;
	logic [MEM_DEPTH-1:0] valid_q;
	logic              valid_hit_q;
	logic              oob_q;
	logic [acdam_pkg::NODE_W-1:0] node_q;
	acdam_pkg::entry_t ram_entry;

	assign wr_in_store = {1'b0, wr.node} < MEM_LIMIT;
	assign rd_in_store = {1'b0, rd.node} < MEM_LIMIT;

	acdam_ram #(
		.WIDTH (EW),
		.DEPTH (MEM_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (wr.en && wr_in_store),
		.waddr (wr.node[AW-1:0]),
		.wdata (wr.entry),
		.re    (rd.en && rd_in_store),
		.raddr (rd.node[AW-1:0]),
		.rdata (ram_entry)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			valid_hit_q <= 1'b0;
			oob_q       <= 1'b1;
			node_q      <= acdam_pkg::NULL_NODE;
		end else begin
			if (wr.en && wr_in_store) begin
				valid_q[wr.node[AW-1:0]] <= 1'b1;
			end
			if (rd.en) begin
				oob_q       <= !rd_in_store;
				node_q      <= rd.node;
				valid_hit_q <= rd_in_store && valid_q[rd.node[AW-1:0]];
			end
		end
	end

	always_comb begin
		if (oob_q) begin
			rd_entry = '0;
		end else begin
			rd_entry.base = ram_entry.base;
			rd_entry.fail = ram_entry.fail;
			// unwritten check entries: root reads minus one, others zero
			if (valid_hit_q) begin
				rd_entry.check = ram_entry.check;
			end else if (node_q == acdam_pkg::ROOT_NODE) begin
				rd_entry.check = '1;
			end else begin
				rd_entry.check = '0;
			end
		end
	end

endmodule

[design/aho_corasick_double_array_match_core.sv]
// ----------------------------------------------------------------------------
// aho_corasick_double_array_match_core
// Multi-pattern text matcher over a software-built double-array automaton.
// ----------------------------------------------------------------------------
// Load words (tuser = 0) write one base/check/fail entry and return nothing.
// Symbol words (tuser = 1) return one result word each: the node reached,
// the number of pattern ends on its output chain and a saturating running
// total; restart sends the automaton back to the root and clears the total
// first. After a symbol word is taken the input stays closed while the walk
// follows fail links, falling back to the root if none leads on, then the
// output chain, and while a waiting result word holds it. A hop whose edge
// index leaves the table or whose letter is outside the alphabet skips the
// check. Each walk stops after at most 255 hops or at a null node, and each
// hop reads the table RAM with registered data, so the walk of dependent
// reads sets the rate.
// Table reads of entries never loaded are undefined, except check entries.
// ----------------------------------------------------------------------------
module aho_corasick_double_array_match_core #(
	parameter int TABLE_DEPTH   = 256,
	parameter int ALPHABET_SIZE = 26
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// entry_addr[7:0], entry_base[15:8], entry_check[24:16], entry_fail[32:25],
	// symbol[37:33], restart[38], zero[39]
	input  logic [39:0] s_axis_tdata,
	// mode[0]
	input  logic        s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// node_index[7:0], matches_here[15:8], total_matches[31:16]
	output logic [31:0] m_axis_tdata
);

	localparam int NW = acdam_pkg::NODE_W;
	localparam logic [8:0] SYM_LIMIT = 9'(ALPHABET_SIZE);

	acdam_pkg::state_t state_q, state_d;
	acdam_pkg::rd_req_t rd;
	acdam_pkg::wr_req_t wr;
	acdam_pkg::entry_t  rd_entry;

	logic [NW-1:0]                  cur_q;
	logic [acdam_pkg::TOTAL_W-1:0]  total_q;
	logic [NW-1:0]                  p_q;
	logic [NW-1:0]                  next_q;
	logic [acdam_pkg::FAIL_W-1:0]   fail_q;
	logic [acdam_pkg::SYM_W-1:0]    sym_q;
	logic [NW-1:0]                  steps_q;
	logic [acdam_pkg::COUNT_W-1:0]  count_q;
	logic                           out_valid_q;
	logic [31:0]                    out_data_q;

	logic                           in_fire;
	logic                           walk_end;
	logic [NW:0]                    edge_idx;
	logic                           edge_ok;
	logic [acdam_pkg::CHECK_W:0]    check_mag;
	logic                           check_hit;
	logic                           out_free;
	logic [acdam_pkg::TOTAL_W:0]    total_sum;
	logic [acdam_pkg::TOTAL_W-1:0]  total_new;

	acdam_store #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (wr),
		.rd       (rd),
		.rd_entry (rd_entry)
	);

	assign in_fire  = s_axis_tvalid && s_axis_tready;
	assign walk_end = (p_q == acdam_pkg::NULL_NODE) || (steps_q == acdam_pkg::WALK_LIMIT);
	assign out_free = !out_valid_q || m_axis_tready;

	// shared index / compare unit
	assign edge_idx  = {1'b0, rd_entry.base} + (NW + 1)'(sym_q);
	assign edge_ok   = ({4'b0, sym_q} < SYM_LIMIT) && !edge_idx[NW];
	assign check_mag = rd_entry.check[acdam_pkg::CHECK_W-1] ?
		-{rd_entry.check[acdam_pkg::CHECK_W-1], rd_entry.check} :
		{1'b0, rd_entry.check};
	assign check_hit = check_mag == (acdam_pkg::CHECK_W + 1)'(p_q);

	assign total_sum = {1'b0, total_q} + (acdam_pkg::TOTAL_W + 1)'(count_q);
	assign total_new = total_sum[acdam_pkg::TOTAL_W] ? acdam_pkg::TOTAL_MAX :
		total_sum[acdam_pkg::TOTAL_W-1:0];

	assign wr.en          = in_fire && (s_axis_tuser == acdam_pkg::MODE_LOAD);
	assign wr.node        = s_axis_tdata[7:0];
	assign wr.entry.base  = s_axis_tdata[15:8];
	assign wr.entry.check = s_axis_tdata[24:16];
	assign wr.entry.fail  = s_axis_tdata[32:25];

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			acdam_pkg::ST_IDLE: begin
				if (in_fire && s_axis_tuser == acdam_pkg::MODE_SYMBOL) begin
					state_d = acdam_pkg::ST_FAIL_RD;
				end
			end
			acdam_pkg::ST_FAIL_RD: begin
				state_d = walk_end ? acdam_pkg::ST_CHAIN_RD : acdam_pkg::ST_EDGE;
			end
			acdam_pkg::ST_EDGE: begin
				state_d = edge_ok ? acdam_pkg::ST_CHECK : acdam_pkg::ST_FAIL_RD;
			end
			acdam_pkg::ST_CHECK: begin
				state_d = check_hit ? acdam_pkg::ST_CHAIN_RD : acdam_pkg::ST_FAIL_RD;
			end
			acdam_pkg::ST_CHAIN_RD: begin
				state_d = walk_end ? acdam_pkg::ST_DONE : acdam_pkg::ST_CHAIN_EV;
			end
			acdam_pkg::ST_CHAIN_EV: begin
				state_d = acdam_pkg::ST_CHAIN_RD;
			end
			acdam_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = acdam_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = acdam_pkg::ST_IDLE;
			end
		endcase
	end

	// control outputs
	always_comb begin
		s_axis_tready = 1'b0;
		rd.en         = 1'b0;
		rd.node       = p_q;
		unique case (state_q)
			acdam_pkg::ST_IDLE: begin
				s_axis_tready = 1'b1;
			end
			acdam_pkg::ST_FAIL_RD, acdam_pkg::ST_CHAIN_RD: begin
				rd.en = !walk_end;
			end
			acdam_pkg::ST_EDGE: begin
				rd.en   = edge_ok;
				rd.node = edge_idx[NW-1:0];
			end
			default: begin
				rd.en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= acdam_pkg::ST_IDLE;
			cur_q       <= acdam_pkg::ROOT_NODE;
			total_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == acdam_pkg::ST_IDLE && in_fire &&
				s_axis_tuser == acdam_pkg::MODE_SYMBOL && s_axis_tdata[38]) begin
				cur_q   <= acdam_pkg::ROOT_NODE;
				total_q <= '0;
			end
			if (state_q == acdam_pkg::ST_DONE && out_free) begin
				cur_q       <= next_q;
				total_q     <= total_new;
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// walk datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			acdam_pkg::ST_IDLE: begin
				sym_q   <= s_axis_tdata[37:33];
				p_q     <= s_axis_tdata[38] ? acdam_pkg::ROOT_NODE : cur_q;
				steps_q <= '0;
			end
			acdam_pkg::ST_FAIL_RD: begin
				if (walk_end) begin
					// no transition anywhere: back to the root
					next_q  <= acdam_pkg::ROOT_NODE;
					p_q     <= acdam_pkg::ROOT_NODE;
					steps_q <= '0;
					count_q <= '0;
				end
			end
			acdam_pkg::ST_EDGE: begin
				fail_q <= rd_entry.fail;
				next_q <= edge_idx[NW-1:0];
				if (!edge_ok) begin
					p_q     <= rd_entry.fail;
					steps_q <= steps_q + NW'(1);
				end
			end
			acdam_pkg::ST_CHECK: begin
				if (check_hit) begin
					p_q     <= next_q;
					steps_q <= '0;
					count_q <= '0;
				end else begin
					p_q     <= fail_q;
					steps_q <= steps_q + NW'(1);
				end
			end
			acdam_pkg::ST_CHAIN_EV: begin
				if (p_q != acdam_pkg::ROOT_NODE && rd_entry.check[acdam_pkg::CHECK_W-1]) begin
					count_q <= count_q + acdam_pkg::COUNT_W'(1);
				end
				p_q     <= rd_entry.fail;
				steps_q <= steps_q + NW'(1);
			end
			acdam_pkg::ST_DONE: begin
				if (out_free) begin
					out_data_q <= {total_new, count_q, next_q};
				end
			end
			default: begin
			end
		endcase
	end

endmodule
